/* rtl/svg_pkg.sv */
`default_nettype none
package svg_pkg;

  localparam int ANGLE_BITS_DEF  = 16;
  localparam int MAX_SEGMENTS    = 1024;
  localparam int COORD_FRAC_BITS = 14;
  localparam int CORDIC_STEPS    = 30;

  localparam int SEG_W   = 11;
  localparam int RING_W  = 10;
  localparam int RIDX_W  = 9;
  localparam int SIDX_W  = 10;
  localparam int COORD_W = 16;
  localparam int ADDR_W  = 19;
  localparam int CW      = 32;   // CORDIC datapath width, Q30 values

  localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(MAX_SEGMENTS);
  localparam logic signed [CW-1:0] CORDIC_ONE_K = 32'sd652032874;

  // Register byte addresses
  localparam logic [2:0] REG_SEGMENT_COUNT = 3'd0;
  localparam logic [2:0] REG_RING_COUNT    = 3'd4;

  localparam logic [SEG_W-1:0]  SEG_RESET  = 11'd64;
  localparam logic [RING_W-1:0] RING_RESET = 10'd32;

  // Arctangent of 2^-k in 2^-32 turn
  localparam logic signed [CW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
    32'sd21354465, 32'sd10679838, 32'sd5340245, 32'sd2670163, 32'sd1335087,
    32'sd667544, 32'sd333772, 32'sd166886, 32'sd83443, 32'sd41722,
    32'sd20861, 32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
    32'sd652, 32'sd326, 32'sd163, 32'sd81, 32'sd41,
    32'sd20, 32'sd10, 32'sd5, 32'sd3, 32'sd1
  };

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              err;
    logic              north;
    logic              south;
  } svg_side_t;

  // Round half up by a constant shift, then clamp to 16 bits
  function automatic logic signed [COORD_W-1:0] rnd_sat(input logic signed [63:0] v,
                                                         input int s);
    logic signed [63:0] t;
    begin
      if (s > 0) begin
        t = (v + (64'sd1 <<< (s - 1))) >>> s;
      end else begin
        t = v;
      end
      if (t > 64'sd32767) begin
        rnd_sat = 16'sh7fff;
      end else if (t < -64'sd32768) begin
        rnd_sat = 16'sh8000;
      end else begin
        rnd_sat = COORD_W'(t);
      end
    end
  endfunction

  localparam logic signed [COORD_W-1:0] POLE_ONE =
    rnd_sat(64'sd1 <<< COORD_FRAC_BITS, 0);

endpackage
`default_nettype wire

/* rtl/sphere_vertex_generator.sv */
`default_nettype none
// Channel | Dir | Fields
// in_     | in  | tdata: ring_index[8:0], segment_index[18:9], zero pad to 24 bits
// out_    | out | tdata: x[15:0] y[31:16] z[47:32] vertex_address[66:48], pad to 72;
//         |     | tuser: index_error
// cfg_    | in  | APB: 0x0 segment_count, 0x4 ring_count
//
// One vertex per clock sustained while the output is not stalled. The path from
// accepted beat to output register runs through one input stage, ANGLE_BITS divider
// stages, 32 CORDIC stages, multiply and round; only the divider depth varies.
// rst_n is synchronous and clears the valid bits and the configuration registers.
// A stall on the output freezes every stage together; no beat is lost.
module sphere_vertex_generator #(
  parameter int ANGLE_BITS = svg_pkg::ANGLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // ring_index[8:0], segment_index[18:9]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // x, y, z, vertex_address, from bit 0
  output logic             out_tuser,  // index_error
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import svg_pkg::*;

  localparam int D = ANGLE_BITS + 34;  // stages after the input register

  // ---------------- configuration registers ----------------
  logic [SEG_W-1:0]  seg_cnt_r;
  logic [RING_W-1:0] ring_cnt_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cnt_r  <= SEG_RESET;
      ring_cnt_r <= RING_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_RING_COUNT[2]) begin
        ring_cnt_r <= cfg_pwdata[RING_W-1:0];
      end else begin
        seg_cnt_r <= cfg_pwdata[SEG_W-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_RING_COUNT[2]) ? 32'(ring_cnt_r) : 32'(seg_cnt_r);

  // ---------------- global advance ----------------
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // ---------------- input stage ----------------
  logic              a_vld_r;
  logic [RIDX_W-1:0] a_ri_r;
  logic [SIDX_W-1:0] a_si_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ri_r <= in_tdata[RIDX_W-1:0];
      a_si_r <= in_tdata[RIDX_W+SIDX_W-1:RIDX_W];
    end
  end

  // Clamp segment count, classify the vertex, form its address
  logic [SEG_W-1:0]          seg_eff;
  logic [RIDX_W+SEG_W-1:0]   addr_full;
  svg_side_t                 side_nxt;

  always_comb begin
    seg_eff        = (seg_cnt_r > SEG_MAX) ? SEG_MAX : seg_cnt_r;
    addr_full      = a_ri_r * seg_eff + (RIDX_W+SEG_W)'(a_si_r);
    side_nxt.err   = (RING_W'(a_ri_r) >= ring_cnt_r) || (SEG_W'(a_si_r) >= seg_eff);
    side_nxt.north = (a_ri_r == '0);
    side_nxt.south = (RING_W'(a_ri_r) == ring_cnt_r - 1'b1);
    side_nxt.addr  = side_nxt.err ? '0 : addr_full[ADDR_W-1:0];
  end

  // ---------------- side-band delay line ----------------
  svg_side_t side_r [D];
  logic      vld_r  [D];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < D; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= a_vld_r;
      for (int i = 1; i < D; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_nxt;
      for (int i = 1; i < D; i++) side_r[i] <= side_r[i-1];
    end
  end

  // ---------------- angle dividers ----------------
  logic [ANGLE_BITS-1:0] pol_q, az_q, pol_ang;

  svg_div #(.QB(ANGLE_BITS), .NW(RIDX_W), .DW(RING_W)) u_div_pol (
    .clk (clk), .en (adv), .num (a_ri_r), .den (ring_cnt_r), .quo (pol_q)
  );

  svg_div #(.QB(ANGLE_BITS), .NW(SIDX_W), .DW(SEG_W)) u_div_az (
    .clk (clk), .en (adv), .num (a_si_r), .den (seg_eff), .quo (az_q)
  );

  // Polar angle spans half a turn: drop one quotient bit
  assign pol_ang = {1'b0, pol_q[ANGLE_BITS-1:1]};

  // ---------------- sine and cosine ----------------
  logic signed [CW-1:0] pc, ps, ac, as_q;

  svg_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_pol (
    .clk (clk), .en (adv), .angle (pol_ang), .cos_q30 (pc), .sin_q30 (ps)
  );

  svg_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_az (
    .clk (clk), .en (adv), .angle (az_q), .cos_q30 (ac), .sin_q30 (as_q)
  );

  // ---------------- multiply ----------------
  logic signed [63:0] px_r, py_r, pz_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= ps * ac;
      py_r <= ps * as_q;
      pz_r <= 64'(pc);
    end
  end

  // ---------------- round, select, output register ----------------
  logic signed [COORD_W-1:0] x_r, y_r, z_r;
  svg_side_t                 sm;

  assign sm = side_r[D-2];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sm.err) begin
        x_r <= '0;
        y_r <= '0;
        z_r <= '0;
      end else if (sm.north) begin
        x_r <= '0;
        y_r <= '0;
        z_r <= POLE_ONE;
      end else if (sm.south) begin
        x_r <= '0;
        y_r <= '0;
        z_r <= -POLE_ONE;
      end else begin
        x_r <= rnd_sat(px_r, 60 - COORD_FRAC_BITS);
        y_r <= rnd_sat(py_r, 60 - COORD_FRAC_BITS);
        z_r <= rnd_sat(pz_r, 30 - COORD_FRAC_BITS);
      end
    end
  end

  assign out_tvalid = vld_r[D-1];
  assign out_tuser  = side_r[D-1].err;
  assign out_tdata  = {5'b0, side_r[D-1].addr, z_r, y_r, x_r};
endmodule
`default_nettype wire

/* rtl/svg_div.sv */
`default_nettype none
module svg_div #(
  parameter int QB = 16,
  parameter int NW = 10,
  parameter int DW = 11
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [QB-1:0] quo
);
  // Restoring division of num * 2^QB by den, one quotient bit per stage
  localparam int RW = DW + 1;

  logic [RW-1:0] rem_r [QB];
  logic [QB-1:0] q_r   [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [RW-1:0] rem_in, t, rem_nxt;
    logic [QB-1:0] q_in, q_nxt;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = RW'(num);
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
    end

    always_comb begin
      t       = {rem_in[RW-2:0], 1'b0};
      ge      = t >= {1'b0, den};
      rem_nxt = ge ? t - {1'b0, den} : t;
      q_nxt   = {q_in[QB-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
      end
    end
  end

  assign quo = q_r[QB-1];
endmodule
`default_nettype wire

/* rtl/svg_cordic.sv */
`default_nettype none
module svg_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [ANGLE_BITS-1:0] angle,
  output logic signed [31:0]         cos_q30,
  output logic signed [31:0]         sin_q30
);
  import svg_pkg::*;

  logic signed [CW-1:0] x_r [CORDIC_STEPS+1];
  logic signed [CW-1:0] y_r [CORDIC_STEPS+1];
  logic signed [CW-1:0] z_r [CORDIC_STEPS+1];
  logic [1:0]           q_r [CORDIC_STEPS+1];
  logic signed [CW-1:0] cos_r, sin_r;

  // Fold to nearest quadrant, residual in [-1/8, 1/8) turn
  logic [CW-1:0] a, rr;
  logic [CW-1:0] a_half;
  logic [1:0]    q_nxt;

  always_comb begin
    a      = {angle, {(CW-ANGLE_BITS){1'b0}}};
    a_half = a + 32'h2000_0000;
    q_nxt  = a_half[CW-1:CW-2];
    rr     = a - {q_nxt, {(CW-2){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_ONE_K;
      y_r[0] <= '0;
      z_r[0] <= signed'(rr);
      q_r[0] <= q_nxt;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic signed [CW-1:0] dx, dy;
    assign dx = y_r[k] >>> k;
    assign dy = x_r[k] >>> k;

    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[k] >= 0) begin
          x_r[k+1] <= x_r[k] - dx;
          y_r[k+1] <= y_r[k] + dy;
          z_r[k+1] <= z_r[k] - ATAN_TURNS[k];
        end else begin
          x_r[k+1] <= x_r[k] + dx;
          y_r[k+1] <= y_r[k] - dy;
          z_r[k+1] <= z_r[k] + ATAN_TURNS[k];
        end
        q_r[k+1] <= q_r[k];
      end
    end
  end

  // Unfold the quadrant by swap and negate
  always_ff @(posedge clk) begin
    if (en) begin
      case (q_r[CORDIC_STEPS])
        2'd0: begin
          cos_r <= x_r[CORDIC_STEPS];
          sin_r <= y_r[CORDIC_STEPS];
        end
        2'd1: begin
          cos_r <= -y_r[CORDIC_STEPS];
          sin_r <= x_r[CORDIC_STEPS];
        end
        2'd2: begin
          cos_r <= -x_r[CORDIC_STEPS];
          sin_r <= -y_r[CORDIC_STEPS];
        end
        default: begin
          cos_r <= y_r[CORDIC_STEPS];
          sin_r <= -x_r[CORDIC_STEPS];
        end
      endcase
    end
  end

  assign cos_q30 = cos_r;
  assign sin_q30 = sin_r;
endmodule
`default_nettype wire
